/* hw/rtl/ccrc_pkg.sv */
// ----------------------------------------------------------------------------
// ccrc_pkg: shared types and constants of the configurable CRC engine
// Register indexes, width-mode codes, the configuration record and the
// bit-reversal and mask helpers used by the datapath.
// ----------------------------------------------------------------------------
package ccrc_pkg;

	// Configuration register index
	typedef logic [2:0] cfg_addr_t;

	localparam cfg_addr_t REG_WIDTH_MODE  = 3'd0;
	localparam cfg_addr_t REG_POLYNOMIAL  = 3'd1;
	localparam cfg_addr_t REG_INIT_VALUE  = 3'd2;
	localparam cfg_addr_t REG_FINAL_XOR   = 3'd3;
	localparam cfg_addr_t REG_REFLECT_IN  = 3'd4;
	localparam cfg_addr_t REG_REFLECT_OUT = 3'd5;

	// CRC register width codes; the unused code behaves as 32 bits
	typedef logic [1:0] width_mode_t;

	localparam width_mode_t MODE_W8  = 2'd0;
	localparam width_mode_t MODE_W16 = 2'd1;
	localparam width_mode_t MODE_W32 = 2'd2;

	// Configuration as seen by the datapath
	typedef struct packed {
		width_mode_t width_mode;
		logic [31:0] polynomial;
		logic [31:0] init_value;
		logic [31:0] final_xor;
		logic        reflect_input;
		logic        reflect_output;
	} ccrc_cfg_t;

	// Datapath results for one beat
	typedef struct packed {
		logic [31:0] crc_next;
		logic [31:0] crc_final;
	} ccrc_step_t;

	// Keep only the bits of the selected width
	function automatic logic [31:0] width_mask(input width_mode_t mode);
		logic [31:0] m;
		case (mode)
			MODE_W8:  m = 32'h0000_00FF;
			MODE_W16: m = 32'h0000_FFFF;
			default:  m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// Mirror a byte
	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[k] = v[7 - k];
		end
		return r;
	endfunction

	// Mirror a 32-bit word
	function automatic logic [31:0] rev32(input logic [31:0] v);
		logic [31:0] r;
		for (int k = 0; k < 32; k++) begin
			r[k] = v[31 - k];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/ccrc_byte_if.sv */
// ----------------------------------------------------------------------------
// ccrc_byte_if: message byte channel
// One beat carries a byte, an end-of-message flag and an empty-item flag.
// ----------------------------------------------------------------------------
interface ccrc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       no_byte;

	modport source (output valid, data_byte, last_byte, no_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, no_byte, output ready);
endinterface

/* hw/rtl/ccrc_result_if.sv */
// ----------------------------------------------------------------------------
// ccrc_result_if: checksum result channel
// One beat carries the finished CRC of one message, zero-extended to 32 bits.
// ----------------------------------------------------------------------------
interface ccrc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_value;

	modport source (output valid, crc_value, input ready);
	modport sink   (input valid, crc_value, output ready);
endinterface

/* hw/rtl/ccrc_cfg_if.sv */
// ----------------------------------------------------------------------------
// ccrc_cfg_if: configuration write channel
// One beat writes one configuration register selected by addr.
// ----------------------------------------------------------------------------
interface ccrc_cfg_if;
	logic                valid;
	logic                ready;
	ccrc_pkg::cfg_addr_t addr;
	logic [31:0]         wdata;

	modport source (output valid, addr, wdata, input ready);
	modport sink   (input valid, addr, wdata, output ready);
endinterface

/* hw/rtl/ccrc_step.sv */
// ----------------------------------------------------------------------------
// ccrc_step: one-byte CRC update
// Folds one byte into the running register with eight reflected shift steps
// and forms the finished checksum for a closing beat.
// ----------------------------------------------------------------------------
module ccrc_step (
	input  ccrc_pkg::ccrc_cfg_t  cfg,
	input  logic [31:0]          running_crc,
	input  logic                 in_message,
	input  logic [7:0]           data_byte,
	input  logic                 no_byte,
	output ccrc_pkg::ccrc_step_t step
);
	import ccrc_pkg::*;

	logic [31:0] mask;
	logic [31:0] poly;
	logic [31:0] crc_start;
	logic [7:0]  byte_in;
	logic [31:0] crc_shift;
	logic [31:0] crc_upd;
	logic [31:0] crc_rev;
	logic [31:0] crc_refl;

	// Pick the start value: fresh init or the open message's register
	always_comb begin
		mask      = width_mask(cfg.width_mode);
		poly      = cfg.polynomial & mask;
		crc_start = (in_message ? running_crc : cfg.init_value) & mask;
	end

	// Take in the byte and run eight reflected shift steps
	always_comb begin
		byte_in   = cfg.reflect_input ? rev8(data_byte) : data_byte;
		crc_shift = crc_start ^ {24'd0, byte_in};
		for (int k = 0; k < 8; k++) begin
			if (crc_shift[0]) begin
				crc_shift = (crc_shift >> 1) ^ poly;
			end else begin
				crc_shift = crc_shift >> 1;
			end
		end
		crc_upd = no_byte ? crc_start : (crc_shift & mask);
	end

	// Mirror across the selected width and apply the output XOR
	always_comb begin
		crc_rev = rev32(crc_upd);
		case (cfg.width_mode)
			MODE_W8:  crc_refl = {24'd0, crc_rev[31:24]};
			MODE_W16: crc_refl = {16'd0, crc_rev[31:16]};
			default:  crc_refl = crc_rev;
		endcase
		step.crc_next  = crc_upd;
		step.crc_final = ((cfg.reflect_output ? crc_refl : crc_upd) ^ cfg.final_xor) & mask;
	end

endmodule

/* hw/rtl/configurable_crc_engine_unit.sv */
// ----------------------------------------------------------------------------
// configurable_crc_engine_unit: byte-serial CRC engine, 8/16/32-bit reflected
// Runs a configurable CRC over a stream of message bytes and emits one
// checksum per message.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    - register writes (width mode, polynomial, init, final XOR, input
//            and output reflection); always ready; write only while idle.
//   msg    - one byte per beat; last_byte closes the message; no_byte marks
//            a beat without data (with last_byte it closes the open message,
//            or an empty one if none is open; without it the beat is dropped).
//   result - one beat per closed message carrying crc_value.
// Datapath: a beat is taken into an input register, and the eight-step
//   byte update runs between that register and the running CRC / result
//   register. One byte per cycle is sustained while no closing beat waits
//   on a full result register; the running-CRC feedback through the eight
//   shift steps is the critical loop.
// Stall: while a result waits on result.ready the input register still
//   drains non-closing beats; a closing beat waits there, and msg.ready drops
//   only when that register cannot move.
// Reset: all configuration registers clear to zero, no message is open and
//   both channels are empty.
// ----------------------------------------------------------------------------
module configurable_crc_engine_unit (
	input logic          clk,
	input logic          arst_n,
	ccrc_cfg_if.sink     cfg,
	ccrc_byte_if.sink    msg,
	ccrc_result_if.source result
);
	import ccrc_pkg::*;

	ccrc_cfg_t   cfg_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        none_s1;
	logic [31:0] running_crc_q;
	logic        in_message_q;
	logic        res_valid_q;
	logic [31:0] crc_value_q;

	logic        msg_accept;
	logic        s1_fire;
	logic        res_free;
	ccrc_step_t  step;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				REG_WIDTH_MODE:  cfg_q.width_mode     <= cfg.wdata[1:0];
				REG_POLYNOMIAL:  cfg_q.polynomial     <= cfg.wdata;
				REG_INIT_VALUE:  cfg_q.init_value     <= cfg.wdata;
				REG_FINAL_XOR:   cfg_q.final_xor      <= cfg.wdata;
				REG_REFLECT_IN:  cfg_q.reflect_input  <= cfg.wdata[0];
				REG_REFLECT_OUT: cfg_q.reflect_output <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves unless a closing beat finds the
	// result register full
	assign res_free   = !res_valid_q || result.ready;
	assign s1_fire    = valid_s1 && (!last_s1 || res_free);
	assign msg.ready  = !valid_s1 || s1_fire;
	assign msg_accept = msg.valid && msg.ready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_accept) begin
			data_s1 <= msg.data_byte;
			last_s1 <= msg.last_byte;
			none_s1 <= msg.no_byte;
		end
	end

	// Byte update
	ccrc_step u_step (
		.cfg         (cfg_q),
		.running_crc (running_crc_q),
		.in_message  (in_message_q),
		.data_byte   (data_s1),
		.no_byte     (none_s1),
		.step        (step)
	);

	// Running CRC: close on the last beat, advance on data beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			in_message_q  <= 1'b0;
		end else if (s1_fire && last_s1) begin
			running_crc_q <= '0;
			in_message_q  <= 1'b0;
		end else if (s1_fire && !none_s1) begin
			running_crc_q <= step.crc_next;
			in_message_q  <= 1'b1;
		end
	end

	// Result register: load on a closing beat, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			crc_value_q <= step.crc_final;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.crc_value = crc_value_q;

	// Checks
	a_closed_is_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_message_q |-> (running_crc_q == 32'd0))
		else $error("running CRC not cleared outside a message");

	a_close_ends_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> (!in_message_q && res_valid_q))
		else $error("closing beat did not end message and post result");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_fire) |=> (valid_s1 && $stable(data_s1) && $stable(last_s1)
			&& $stable(none_s1)))
		else $error("stalled input stage lost its beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |-> res_free)
		else $error("result register overwritten before it was taken");

endmodule

/* test/configurable_crc_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// configurable_crc_engine_unit_tb: self-checking bench for the CRC engine
// Streams message bytes through the engine under a series of CRC setups
// (8, 16 and 32 bits, spare width code, reflection on and off, extreme
// polynomial, init and final XOR values). A bit-level CRC tracker predicts
// each checksum when its closing beat is accepted, and every result beat is
// compared against the oldest predicted checksum. The sender runs in bursts
// and the receiver stalls in changing patterns, including one long hold-off.
// ----------------------------------------------------------------------------
module configurable_crc_engine_unit_tb;
	import ccrc_pkg::*;

	// Width code outside the named modes; the engine treats it as 32 bits
	localparam width_mode_t MODE_SPARE = 2'd3;

	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 700;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       no_byte;
	} msg_beat_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLINK} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	ccrc_cfg_if    cfg_ch ();
	ccrc_byte_if   msg_ch ();
	ccrc_result_if res_ch ();

	configurable_crc_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.msg    (msg_ch),
		.result (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Tracker state: configuration copy and the open message's CRC
	ccrc_cfg_t   crc_cfg;
	logic [31:0] crc_run  = '0;
	logic        crc_open = 1'b0;

	msg_beat_t   beat_queue[$];
	logic [31:0] crc_expect[$];
	int          stim_count;
	int          beats_taken = 0;
	int          err_count   = 0;

	// Fold one beat into the tracked CRC; return 1 when it closes a message
	function automatic bit crc_absorb(input msg_beat_t b, output logic [31:0] crc_out);
		logic [31:0] mask;
		logic [31:0] crc;
		logic [31:0] mirrored;
		logic [7:0]  byte_in;
		int          nbits;
		crc_out = '0;
		case (crc_cfg.width_mode)
			MODE_W8: begin
				mask  = 32'h0000_00FF;
				nbits = 8;
			end
			MODE_W16: begin
				mask  = 32'h0000_FFFF;
				nbits = 16;
			end
			default: begin
				mask  = 32'hFFFF_FFFF;
				nbits = 32;
			end
		endcase
		// Drop empty beats that do not close anything
		if (b.no_byte && !b.last_byte) begin
			return 1'b0;
		end
		crc = crc_open ? (crc_run & mask) : (crc_cfg.init_value & mask);
		if (!b.no_byte) begin
			byte_in = b.data_byte;
			if (crc_cfg.reflect_input) begin
				for (int k = 0; k < 8; k++) begin
					byte_in[k] = b.data_byte[7 - k];
				end
			end
			crc = (crc ^ {24'd0, byte_in}) & mask;
			for (int k = 0; k < 8; k++) begin
				if (crc[0]) begin
					crc = (crc >> 1) ^ (crc_cfg.polynomial & mask);
				end else begin
					crc = crc >> 1;
				end
			end
			crc = crc & mask;
		end
		if (b.last_byte) begin
			if (crc_cfg.reflect_output) begin
				mirrored = '0;
				for (int k = 0; k < nbits; k++) begin
					mirrored[nbits - 1 - k] = crc[k];
				end
				crc = mirrored;
			end
			crc_out  = (crc ^ crc_cfg.final_xor) & mask;
			crc_run  = '0;
			crc_open = 1'b0;
			return 1'b1;
		end
		crc_run  = crc;
		crc_open = 1'b1;
		return 1'b0;
	endfunction

	// Write one register and mirror it into the tracker on the handshake
	task automatic cfg_write(input cfg_addr_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.wdata <= val;
		do begin
			@(posedge clk);
		end while (!(cfg_ch.valid && cfg_ch.ready));
		case (idx)
			REG_WIDTH_MODE:  crc_cfg.width_mode     = val[1:0];
			REG_POLYNOMIAL:  crc_cfg.polynomial     = val;
			REG_INIT_VALUE:  crc_cfg.init_value     = val;
			REG_FINAL_XOR:   crc_cfg.final_xor      = val;
			REG_REFLECT_IN:  crc_cfg.reflect_input  = val[0];
			REG_REFLECT_OUT: crc_cfg.reflect_output = val[0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic write_crc_setup(input width_mode_t mode, input logic [31:0] poly,
			input logic [31:0] init, input logic [31:0] fxor, input logic rin,
			input logic rout);
		cfg_write(REG_WIDTH_MODE, {30'd0, mode});
		cfg_write(REG_POLYNOMIAL, poly);
		cfg_write(REG_INIT_VALUE, init);
		cfg_write(REG_FINAL_XOR, fxor);
		cfg_write(REG_REFLECT_IN, {31'd0, rin});
		cfg_write(REG_REFLECT_OUT, {31'd0, rout});
	endtask

	// Wait until every queued beat is taken and every checksum has come back
	task automatic wait_idle();
		while (beat_queue.size() != 0 || msg_ch.valid || crc_expect.size() != 0) begin
			@(posedge clk);
		end
		// let a trailing non-closing beat leave the input register
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_beat(input logic [7:0] data, input logic last, input logic none);
		msg_beat_t b;
		b.data_byte = data;
		b.last_byte = last;
		b.no_byte   = none;
		beat_queue.push_back(b);
		if (!(none && !last)) begin
			stim_count++;
		end
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [31:0] pick_word(input logic [31:0] typical);
		case ($urandom_range(0, 4))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return typical;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_poly();
		case ($urandom_range(0, 4))
			0:       return 32'hEDB8_8320;
			1:       return 32'h82F6_3B78;
			2:       return 32'h0000_A001;
			3:       return 32'h0000_8408;
			default: return 32'h0000_008C;
		endcase
	endfunction

	// Walk every width code in the first phases, then choose freely
	function automatic width_mode_t pick_mode(input int phase);
		int sel;
		sel = (phase < 4) ? phase : $urandom_range(0, 3);
		case (sel)
			0:       return MODE_W8;
			1:       return MODE_W16;
			2:       return MODE_W32;
			default: return MODE_SPARE;
		endcase
	endfunction

	// Queue one message; an empty-close beat may end it, or it may stay open
	task automatic push_message(input int len, input bit empty_close, input bit keep_open);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				push_beat(pick_byte(), 1'b0, 1'b1);
			end
			push_beat(pick_byte(), (i == len - 1) && !empty_close && !keep_open, 1'b0);
		end
		if (!keep_open && (empty_close || len == 0)) begin
			push_beat(pick_byte(), 1'b1, 1'b1);
		end
	endtask

	// Sender: hold a beat until taken, offer from the queue in bursts
	msg_beat_t   cur_beat;
	logic [31:0] crc_sum;
	bit          slot_free;
	bit          offer;
	int          burst_left;
	int          gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_ch.valid     <= 1'b0;
			msg_ch.data_byte <= '0;
			msg_ch.last_byte <= 1'b0;
			msg_ch.no_byte   <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			slot_free = !msg_ch.valid;
			if (msg_ch.valid && msg_ch.ready) begin
				if (crc_absorb(cur_beat, crc_sum)) begin
					crc_expect.push_back(crc_sum);
				end
				beats_taken++;
				slot_free = 1'b1;
			end
			if (slot_free) begin
				offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (beat_queue.size() != 0) begin
					offer    = 1'b1;
					cur_beat = beat_queue.pop_front();
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
					end
					burst_left--;
					if (burst_left == 0) begin
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
				msg_ch.valid <= offer;
				if (offer) begin
					msg_ch.data_byte <= cur_beat.data_byte;
					msg_ch.last_byte <= cur_beat.last_byte;
					msg_ch.no_byte   <= cur_beat.no_byte;
				end
			end
		end
	end

	// Receiver: stall in windows of changing pattern, plus one long hold-off
	rx_mode_t rx_mode;
	int       win_left;
	int       hold_left;
	bit       hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			win_left  = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (!hold_done && beats_taken > 150 && beat_queue.size() > 20) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			if (win_left == 0) begin
				rx_mode  = rx_mode_t'($urandom_range(0, 3));
				win_left = $urandom_range(32, 96);
			end
			win_left--;
			case (rx_mode)
				RX_OPEN:   res_ch.ready <= 1'b1;
				RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default:   res_ch.ready <= win_left[1];
			endcase
		end
	end

	// Check each result beat against the oldest predicted checksum
	logic [31:0] crc_want;

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (crc_expect.size() == 0) begin
				$error("unexpected result beat, crc_value actual %h", res_ch.crc_value);
				err_count++;
			end else begin
				crc_want = crc_expect.pop_front();
				if (res_ch.crc_value !== crc_want) begin
					$error("crc_value: expected %h, actual %h", crc_want, res_ch.crc_value);
					err_count++;
				end
			end
		end
	end

	// Stimulus: directed cases, then random setups with random messages
	initial begin
		int phase;
		int target;
		int len;
		int pick;
		arst_n           = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.addr      = REG_WIDTH_MODE;
		cfg_ch.wdata     = '0;
		crc_cfg          = '0;
		stim_count       = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: one message and one empty message
		push_beat(8'hFF, 1'b0, 1'b0);
		push_beat(8'h00, 1'b1, 1'b0);
		push_beat(8'h3C, 1'b1, 1'b1);
		wait_idle();

		// standard 32-bit setup: check string, a dropped empty beat,
		// an empty message and a message closed by an empty beat
		write_crc_setup(MODE_W32, 32'hEDB8_8320, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
		for (int i = 0; i < 9; i++) begin
			push_beat(8'h31 + 8'(i), i == 8, 1'b0);
			if (i == 3) begin
				push_beat(8'hA5, 1'b0, 1'b1);
			end
		end
		push_beat(8'h00, 1'b1, 1'b1);
		push_beat(8'h80, 1'b0, 1'b0);
		push_beat(8'h7F, 1'b1, 1'b1);

		// narrow the width and turn on reflection while a message is open
		push_beat(8'h5A, 1'b0, 1'b0);
		wait_idle();
		cfg_write(REG_WIDTH_MODE, {30'd0, MODE_W8});
		cfg_write(REG_REFLECT_IN, 32'd1);
		cfg_write(REG_REFLECT_OUT, 32'd1);
		push_beat(8'hC3, 1'b1, 1'b0);
		wait_idle();

		// spare width code behaves as 32 bits
		cfg_write(REG_WIDTH_MODE, {30'd0, MODE_SPARE});
		cfg_write(REG_POLYNOMIAL, 32'h82F6_3B78);
		push_beat(8'h01, 1'b0, 1'b0);
		push_beat(8'hFE, 1'b1, 1'b0);
		wait_idle();

		stim_count = 0;
		phase      = 0;
		while (stim_count < RANDOM_ITEMS) begin
			write_crc_setup(pick_mode(phase), pick_word(pick_poly()), pick_word($urandom),
				pick_word($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			target = stim_count + $urandom_range(40, 110);
			while (stim_count < target) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					len = 0;
				end else if (pick == 1) begin
					len = $urandom_range(12, 24);
				end else begin
					len = $urandom_range(1, 6);
				end
				push_message(len, $urandom_range(0, 6) == 0, 1'b0);
			end
			// sometimes carry an open message across the next setup change
			if ($urandom_range(0, 3) == 0) begin
				push_message($urandom_range(1, 3), 1'b0, 1'b1);
			end
			wait_idle();
			phase++;
		end

		repeat (16) @(posedge clk);
		if (err_count == 0) begin
			$display("PASS configurable_crc_engine_unit");
		end else begin
			$display("FAIL configurable_crc_engine_unit");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("FAIL configurable_crc_engine_unit");
		$finish;
	end

endmodule

/* configurable_crc_engine_unit.f */
hw/rtl/ccrc_pkg.sv
hw/rtl/ccrc_byte_if.sv
hw/rtl/ccrc_result_if.sv
hw/rtl/ccrc_cfg_if.sv
hw/rtl/ccrc_step.sv
hw/rtl/configurable_crc_engine_unit.sv
test/configurable_crc_engine_unit_tb.sv
